// ----- hw/rtl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes, constants and the alignment table of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int BBA_BITMAP_WORDS = 64;
    localparam int BBA_BLOCK_BYTES  = 1024;
    localparam int WORD_BITS        = 32;

    localparam logic [31:0] ALL_USED = 32'hFFFF_FFFF;

    // Request actions.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Response status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_BAD_COUNT = 2'd2;
    localparam logic [1:0] ST_BAD_ADDR  = 2'd3;

    // Configuration register indexes.
    localparam logic REG_REGION_BASE = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

    typedef struct packed {
        logic        action;
        logic [5:0]  count;
        logic [5:0]  alignment;
        logic [31:0] free_address;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] block_address;
    } rsp_t;

    typedef struct packed {
        logic       found;
        logic       touched;
        logic [4:0] start;
    } scan_res_t;

    // Mask of count low bits; count is 1 to 32 wherever it is used.
    function automatic logic [31:0] len_mask(input logic [5:0] count);
        logic [31:0] m;
        if (count[5])
        begin
            m = ALL_USED;
        end
        else
        begin
            m = (32'd1 << count[4:0]) - 32'd1;
        end
        return m;
    endfunction

    // For every alignment code, the start bits that are multiples of it.
    // A code of zero acts as one; codes above 32 leave only bit zero.
    function automatic logic [63:0][31:0] align_table();
        logic [63:0][31:0] t;
        int step;
        int nxt;
        for (int a = 0; a < 64; a++)
        begin
            step = (a == 0) ? 1 : a;
            nxt  = 0;
            t[a] = '0;
            for (int s = 0; s < WORD_BITS; s++)
            begin
                if (s == nxt)
                begin
                    t[a][s] = 1'b1;
                    nxt     = nxt + step;
                end
            end
        end
        return t;
    endfunction

    localparam logic [63:0][31:0] ALIGN_TABLE = align_table();

endpackage

// ----- hw/rtl/bitmap_block_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// Allocate: words are read from the hint on (at most BITMAP_WORDS) until a run
// fits, which is written back and turned into an address (multiply, sum); else NO_SPACE.
// Free: block index, word read, write back; a bad count or address skips the remaining steps.
// One request is worked at a time; a new one is taken while a response waits.
// After reset a clearing sweep writes zero to all BITMAP_WORDS words, one per
// cycle, with req_stall high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit
    import bba_pkg::*;
#(
    parameter int BITMAP_WORDS = BBA_BITMAP_WORDS,
    parameter int BLOCK_BYTES  = BBA_BLOCK_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int CW = AW + 1;
    localparam logic [63:0] FREE_SPAN = 64'(4096) * 64'(BLOCK_BYTES);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_MUL     = 4'd3;
    localparam logic [3:0] S_SUM     = 4'd4;
    localparam logic [3:0] S_DIV     = 4'd5;
    localparam logic [3:0] S_FREE_RD = 4'd6;
    localparam logic [3:0] S_FREE_WR = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [31:0]   region_base_reg, region_base_next;
    logic [11:0]   block_count_reg, block_count_next;
    logic [AW-1:0] hint_reg, hint_next;
    logic          hint_set_reg, hint_set_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] limit_reg, limit_next;
    logic [AW-1:0] ev_idx_reg, ev_idx_next;
    logic          pend_reg, pend_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [31:0]   amask_reg, amask_next;
    logic [AW+4:0] blkidx_reg, blkidx_next;
    logic [31:0]   prod_reg, prod_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [31:0]   mem_rd_data;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [31:0]   mem_wr_data;

    scan_res_t     scan_res;
    logic [31:0]   scan_new_word;

    logic          div_start;
    logic [31:0]   div_dividend;
    logic          div_done;
    logic [11:0]   div_quo;

    logic          req_take;
    logic [7:0]    words_full;
    logic [AW-1:0] free_word;

    bba_bitmap_mem #(
        .DEPTH (BITMAP_WORDS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    bba_word_scan #(
        .AW (AW)
    ) u_scan (
        .word        (mem_rd_data),
        .word_idx    (ev_idx_reg),
        .block_count (block_count_reg),
        .count       (cnt_reg),
        .align_mask  (amask_reg),
        .result      (scan_res),
        .new_word    (scan_new_word)
    );

    bba_blk_div #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign req_stall    = (state_reg != S_IDLE);
    assign req_take     = req_valid && !req_stall;
    assign cfg_ready    = 1'b1;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;
    assign div_dividend = req.free_address - region_base_reg;
    assign words_full   = {1'b0, block_count_reg[11:5]} + 8'd1;
    assign free_word    = AW'(div_quo >> 5);

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        region_base_next = region_base_reg;
        block_count_next = block_count_reg;
        hint_next        = hint_reg;
        hint_set_next    = hint_set_reg;
        rd_idx_next      = rd_idx_reg;
        limit_next       = limit_reg;
        ev_idx_next      = ev_idx_reg;
        pend_next        = pend_reg;
        cnt_next         = cnt_reg;
        amask_next       = amask_reg;
        blkidx_next      = blkidx_reg;
        prod_next        = prod_reg;
        res_status_next  = res_status_reg;
        res_addr_next    = res_addr_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_next         = rsp_reg;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = '0;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = '0;
        mem_wr_data      = '0;
        div_start        = 1'b0;

        if (cfg_valid)
        begin
            if (cfg_index == REG_REGION_BASE)
            begin
                region_base_next = cfg_data;
            end
            else
            begin
                block_count_next = cfg_data[11:0];
            end
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_addr_reg;
                if (clr_addr_reg == AW'(BITMAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (req_take)
                begin
                    cnt_next      = req.count;
                    amask_next    = ALIGN_TABLE[req.alignment];
                    res_addr_next = '0;
                    if (req.count == 6'd0 || req.count > 6'd32)
                    begin
                        res_status_next = ST_BAD_COUNT;
                        state_next      = S_DONE;
                    end
                    else if (req.action == ACT_ALLOC)
                    begin
                        if (32'(words_full) >= BITMAP_WORDS)
                        begin
                            limit_next = CW'(BITMAP_WORDS);
                        end
                        else
                        begin
                            limit_next = CW'(words_full);
                        end
                        rd_idx_next   = CW'(hint_reg);
                        pend_next     = 1'b0;
                        hint_set_next = 1'b0;
                        state_next    = S_SCAN;
                    end
                    else if (req.free_address < region_base_reg ||
                             64'(div_dividend) >= FREE_SPAN)
                    begin
                        res_status_next = ST_BAD_ADDR;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end

            S_SCAN:
            begin
                // Reads run one word ahead of the word being evaluated.
                if (pend_reg && scan_res.found)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = ev_idx_reg;
                    mem_wr_data = scan_new_word;
                    if (!hint_set_reg)
                    begin
                        hint_next = ev_idx_reg;
                    end
                    blkidx_next = {ev_idx_reg, scan_res.start};
                    pend_next   = 1'b0;
                    state_next  = S_MUL;
                end
                else
                begin
                    if (pend_reg && scan_res.touched && !hint_set_reg)
                    begin
                        hint_next     = ev_idx_reg;
                        hint_set_next = 1'b1;
                    end
                    if (rd_idx_reg < limit_reg)
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(rd_idx_reg);
                        ev_idx_next = AW'(rd_idx_reg);
                        rd_idx_next = rd_idx_reg + CW'(1);
                        pend_next   = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        if (!pend_reg)
                        begin
                            res_status_next = ST_NO_SPACE;
                            state_next      = S_DONE;
                        end
                    end
                end
            end

            S_MUL:
            begin
                prod_next  = 32'(blkidx_reg) * 32'(BLOCK_BYTES);
                state_next = S_SUM;
            end

            S_SUM:
            begin
                res_addr_next   = region_base_reg + prod_reg;
                res_status_next = ST_OK;
                state_next      = S_DONE;
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_quo >= block_count_reg ||
                        32'(div_quo[11:5]) >= BITMAP_WORDS ||
                        (6'd32 - {1'b0, div_quo[4:0]}) < cnt_reg)
                    begin
                        res_status_next = ST_BAD_ADDR;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FREE_RD;
                    end
                end
            end

            S_FREE_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = free_word;
                state_next  = S_FREE_WR;
            end

            S_FREE_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = free_word;
                mem_wr_data = mem_rd_data & ~(len_mask(cnt_reg) << div_quo[4:0]);
                if (free_word < hint_reg)
                begin
                    hint_next = free_word;
                end
                res_status_next = ST_OK;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.status        = res_status_reg;
                    rsp_next.block_address = res_addr_reg;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            region_base_reg <= '0;
            block_count_reg <= '0;
            hint_reg        <= '0;
            hint_set_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            limit_reg       <= '0;
            ev_idx_reg      <= '0;
            pend_reg        <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            region_base_reg <= region_base_next;
            block_count_reg <= block_count_next;
            hint_reg        <= hint_next;
            hint_set_reg    <= hint_set_next;
            rd_idx_reg      <= rd_idx_next;
            limit_reg       <= limit_next;
            ev_idx_reg      <= ev_idx_next;
            pend_reg        <= pend_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        amask_reg      <= amask_next;
        blkidx_reg     <= blkidx_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        rsp_reg        <= rsp_next;
    end

endmodule

// ----- hw/rtl/bba_bitmap_mem.sv -----
// ----------------------------------------------------------------------------
// bba_bitmap_mem
// Bitmap store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_bitmap_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/bba_word_scan.sv -----
// ----------------------------------------------------------------------------
// bba_word_scan
// Evaluates one bitmap word: finds the first aligned free run that fits.
// ----------------------------------------------------------------------------
module bba_word_scan
    import bba_pkg::*;
#(
    parameter int AW = 6
) (
    input  logic [31:0]   word,
    input  logic [AW-1:0] word_idx,
    input  logic [11:0]   block_count,
    input  logic [5:0]    count,
    input  logic [31:0]   align_mask,
    output scan_res_t     result,
    output logic [31:0]   new_word
);

    logic [15:0] first_blk;
    logic [15:0] avail;
    logic [31:0] past;
    logic [31:0] used;
    logic [31:0] run;
    logic [31:0] fits;
    logic [31:0] cand;
    logic [4:0]  start;

    // Blocks at or past block_count count as used.
    always_comb
    begin
        first_blk = 16'(word_idx) << 5;
        avail     = 16'(block_count) - first_blk;
        if (16'(block_count) <= first_blk)
        begin
            past = ALL_USED;
        end
        else if (avail >= 16'd32)
        begin
            past = '0;
        end
        else
        begin
            past = ~((32'd1 << avail[4:0]) - 32'd1);
        end
        used = word | past;
    end

    always_comb
    begin
        run = len_mask(count);
        for (int s = 0; s < WORD_BITS; s++)
        begin
            fits[s] = ((6'(s) + count) <= 6'd32);
            cand[s] = align_mask[s] && fits[s] && ((used & (run << s)) == '0);
        end
        start = '0;
        for (int s = WORD_BITS - 1; s >= 0; s--)
        begin
            if (cand[s])
            begin
                start = 5'(s);
            end
        end
        result.found   = |cand;
        result.touched = |(align_mask & fits & ~used);
        result.start   = start;
        new_word       = word | (run << start);
    end

endmodule

// ----- hw/rtl/bba_blk_div.sv -----
// ----------------------------------------------------------------------------
// bba_blk_div
// Turns a byte offset below 4096 blocks into a registered block index.
// ----------------------------------------------------------------------------
module bba_blk_div #(
    parameter int BLOCK_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    output logic        done,
    output logic [11:0] quotient
);

    // Block sizes must be powers of two, which this block leaves to the user; the index is the offset shifted down.
    localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);

    logic        done_reg;
    logic        done_next;
    logic [11:0] quo_reg;
    logic [11:0] quo_next;
    logic [31:0] shifted;

    always_comb
    begin
        shifted   = dividend >> BLK_SHIFT;
        done_next = start;
        quo_next  = quo_reg;
        if (start)
        begin
            quo_next = shifted[11:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hw/rtl/bba_checker.sv -----
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks on the allocator's request and response channels.
// ----------------------------------------------------------------------------
module bba_checker
    import bba_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // Requests taken whose responses have not been taken yet.
    logic [1:0] pend_cnt_reg;
    logic [1:0] pend_cnt_next;
    logic       req_take;
    logic       rsp_take;

    assign req_take = req_valid && !req_stall;
    assign rsp_take = rsp_valid && !rsp_stall;

    always_comb
    begin
        unique case ({req_take, rsp_take})
            2'b10:   pend_cnt_next = pend_cnt_reg + 2'd1;
            2'b01:   pend_cnt_next = pend_cnt_reg - 2'd1;
            default: pend_cnt_next = pend_cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= '0;
        end
        else
        begin
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_cnt_reg != 2'd0)
        else $error("response without an open request");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |-> pend_cnt_reg <= 2'd1)
        else $error("request taken while another is still being worked");

    a_err_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.block_address == '0)
        else $error("failed request returned a nonzero address");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (.*);
